>>> src/cfm_pkg.sv
// ----------------------------------------------------------------------------
// cfm_pkg - shared types and constants for the command frame matcher
// Holds the command name table, character codes and result status codes.
// ----------------------------------------------------------------------------
package cfm_pkg;

    localparam int BYTE_W           = 8;
    localparam int ARG_W            = 32;
    localparam int INDEX_W          = 3;
    localparam int TABLE_SIZE       = 6;
    localparam int NAME_BUF         = 8;
    localparam int NUM_COMMANDS_DEF = 6;
    localparam int MAX_NAME_LEN_DEF = 16;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [ARG_W-1:0]   t_arg;
    typedef logic [INDEX_W-1:0] t_index;

    typedef enum logic [1:0] {
        ST_WRONG_STRING = 2'd0,
        ST_WRONG_FRAME  = 2'd1,
        ST_RIGHT_FRAME  = 2'd2
    } t_status;

    localparam t_byte SEP_CHAR = 8'h5F;  // '_'
    localparam t_byte DIGIT_LO = 8'h30;  // '0'
    localparam t_byte DIGIT_HI = 8'h39;  // '9'
    localparam logic [BYTE_W:0] CASE_GAP = 9'd32;

    // Command names, padded with zero bytes past their length
    localparam t_byte CMD_NAMES [TABLE_SIZE][NAME_BUF] = '{
        '{8'h53, 8'h65, 8'h72, 8'h76, 8'h6F, 8'h31, 8'h00, 8'h00},  // Servo1
        '{8'h53, 8'h65, 8'h72, 8'h76, 8'h6F, 8'h32, 8'h00, 8'h00},  // Servo2
        '{8'h52, 8'h65, 8'h6C, 8'h61, 8'h79, 8'h6F, 8'h66, 8'h66},  // Relayoff
        '{8'h52, 8'h65, 8'h6C, 8'h61, 8'h79, 8'h6F, 8'h6E, 8'h00},  // Relayon
        '{8'h6C, 8'h65, 8'h64, 8'h6F, 8'h66, 8'h66, 8'h00, 8'h00},  // ledoff
        '{8'h4C, 8'h65, 8'h64, 8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00}   // Ledon
    };

    localparam logic [3:0] CMD_LENS [TABLE_SIZE] = '{4'd6, 4'd6, 4'd8, 4'd7, 4'd6, 4'd5};

endpackage

>>> src/command_frame_matcher.sv
// ----------------------------------------------------------------------------
// command_frame_matcher - matches name_number command frames
// Checks each name byte against a fixed command table (case-insensitive by
// the 32 code gap), collects the decimal argument after the underscore and
// reports one result per frame on its final byte.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_stall   i_char_byte, i_is_last
//  out       source     o_out_valid / i_out_stall o_frame_status,
//                                                 o_command_index, o_argument_value
//
//  - One byte per cycle sustained while the input is not stalled. A byte lands
//    in the input register, from which the compare/multiply-by-ten path updates
//    the frame state; the final byte of a frame loads the result register, so a
//    result shows once its last byte has passed both registers in that order.
//  - The register-to-register path is the table compare plus the acc*10+digit add.
//  - i_rst_n is synchronous and active low; it clears the frame state and the
//    valid flags of the input register and the result register.
//  - The input stalls only while a final byte sits in the input register and
//    the previous result is still held by a stalled output.
//
module command_frame_matcher #(
    parameter int NUM_COMMANDS = cfm_pkg::NUM_COMMANDS_DEF,
    parameter int MAX_NAME_LEN = cfm_pkg::MAX_NAME_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  cfm_pkg::t_byte         i_char_byte,
    input  logic                   i_is_last,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_frame_status,
    output cfm_pkg::t_index        o_command_index,
    output cfm_pkg::t_arg          o_argument_value
);
    import cfm_pkg::*;

    localparam int POS_W  = $clog2(MAX_NAME_LEN + 1);
    localparam int ACTIVE = (NUM_COMMANDS < TABLE_SIZE) ? NUM_COMMANDS : TABLE_SIZE;
    localparam logic [NUM_COMMANDS-1:0] FLAGS_INIT =
        NUM_COMMANDS'((32'd1 << ACTIVE) - 32'd1);

    // Input register
    logic                    r_in_valid;
    t_byte                   r_in_byte;
    logic                    r_in_last;

    // Frame state
    logic                    r_number;
    logic                    r_bad;
    logic [POS_W-1:0]        r_pos;
    logic [NUM_COMMANDS-1:0] r_flags;
    t_arg                    r_acc;

    logic                    n_number;
    logic                    n_bad;
    logic [POS_W-1:0]        n_pos;
    logic [NUM_COMMANDS-1:0] n_flags;
    t_arg                    n_acc;

    // Result register
    logic                    r_out_valid;
    t_status                 r_status;
    t_index                  r_index;
    t_arg                    r_arg;

    t_status                 n_status;
    t_index                  n_index;
    t_arg                    n_arg;

    logic                    in_accept;
    logic                    process;
    logic                    is_sep;
    logic [NUM_COMMANDS-1:0] match_flags;
    t_arg                    accum_acc;
    logic                    accum_bad;

    // Hold the input only when a final byte cannot hand over its result
    assign o_in_stall = r_in_valid && r_in_last && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign process    = r_in_valid && !o_in_stall;
    assign is_sep     = (r_in_byte == SEP_CHAR);

    cfm_name_match #(
        .NUM_COMMANDS (NUM_COMMANDS),
        .POS_W        (POS_W)
    ) u_name_match (
        .i_byte   (r_in_byte),
        .i_is_sep (is_sep),
        .i_pos    (r_pos),
        .i_flags  (r_flags),
        .o_flags  (match_flags)
    );

    cfm_arg_accum u_arg_accum (
        .i_byte (r_in_byte),
        .i_acc  (r_acc),
        .i_bad  (r_bad),
        .o_acc  (accum_acc),
        .o_bad  (accum_bad)
    );

    // Next frame state after folding in the byte of the input register
    always_comb begin
        n_number = r_number;
        n_bad    = r_bad;
        n_pos    = r_pos;
        n_flags  = r_flags;
        n_acc    = r_acc;
        if (r_number) begin
            n_acc = accum_acc;
            n_bad = accum_bad;
        end else if (is_sep) begin
            n_flags  = match_flags;
            n_number = 1'b1;
        end else begin
            n_flags = match_flags;
            // Saturate the name position; no command is that long
            if (r_pos < POS_W'(MAX_NAME_LEN)) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    // Result decode: wrong string wins over wrong frame
    always_comb begin
        n_status = ST_WRONG_STRING;
        n_index  = '0;
        n_arg    = '0;
        if (!n_number || n_bad) begin
            n_status = ST_WRONG_STRING;
        end else if (n_flags == '0) begin
            n_status = ST_WRONG_FRAME;
        end else begin
            n_status = ST_RIGHT_FRAME;
            n_arg    = n_acc;
            // Lowest-numbered surviving command wins
            for (int k = NUM_COMMANDS - 1; k >= 0; k--) begin
                if (n_flags[k]) begin
                    n_index = INDEX_W'(k);
                end
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_byte <= i_char_byte;
            r_in_last <= i_is_last;
        end
    end

    // Frame state: return to the start-of-frame state after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number <= 1'b0;
            r_bad    <= 1'b0;
            r_pos    <= '0;
            r_flags  <= FLAGS_INIT;
            r_acc    <= '0;
        end else if (process) begin
            if (r_in_last) begin
                r_number <= 1'b0;
                r_bad    <= 1'b0;
                r_pos    <= '0;
                r_flags  <= FLAGS_INIT;
                r_acc    <= '0;
            end else begin
                r_number <= n_number;
                r_bad    <= n_bad;
                r_pos    <= n_pos;
                r_flags  <= n_flags;
                r_acc    <= n_acc;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (process && r_in_last) begin
            r_status <= n_status;
            r_index  <= n_index;
            r_arg    <= n_arg;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_status   = r_status;
    assign o_command_index  = r_index;
    assign o_argument_value = r_arg;

    // A stall toward the input only ever comes from a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_last))
        else $error("input stalled without a held result");

    // A right frame names a command that exists in the table
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_RIGHT_FRAME) |->
        (r_index < INDEX_W'(ACTIVE)))
        else $error("command index beyond the table");

    // Failed frames carry zero index and argument
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_RIGHT_FRAME) |->
        (r_index == '0 && r_arg == '0))
        else $error("failed frame carries payload");

    // Flags beyond the table never come up
    a_flags_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flags & ~FLAGS_INIT) == '0)
        else $error("flag set beyond the table");

    // After a final byte is processed the frame state is back at its start
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_in_last) |=> (!r_number && !r_bad && r_pos == '0))
        else $error("frame state not cleared after final byte");

endmodule

>>> src/cfm_name_match.sv
// ----------------------------------------------------------------------------
// cfm_name_match - parallel compare of one name byte against the command table
// Clears the flag of every command that the byte rules out.
// ----------------------------------------------------------------------------
module cfm_name_match #(
    parameter int NUM_COMMANDS = cfm_pkg::NUM_COMMANDS_DEF,
    parameter int POS_W        = 5
) (
    input  cfm_pkg::t_byte           i_byte,
    input  logic                     i_is_sep,
    input  logic [POS_W-1:0]         i_pos,
    input  logic [NUM_COMMANDS-1:0]  i_flags,
    output logic [NUM_COMMANDS-1:0]  o_flags
);
    import cfm_pkg::*;

    localparam int NB_W = $clog2(NAME_BUF);

    logic [BYTE_W:0] c_ext;

    assign c_ext = {1'b0, i_byte};

    for (genvar k = 0; k < NUM_COMMANDS; k++) begin : g_cmd
        if (k < TABLE_SIZE) begin : g_live
            logic [BYTE_W:0] t_ext;
            logic            in_range;
            logic            byte_ok;
            logic            keep;

            assign t_ext    = {1'b0, CMD_NAMES[k][i_pos[NB_W-1:0]]};
            assign in_range = (i_pos < POS_W'(CMD_LENS[k])) && (i_pos < POS_W'(NAME_BUF));
            // Equal, or off by the upper/lower case gap in either direction
            assign byte_ok  = (c_ext == t_ext) || ((c_ext + CASE_GAP) == t_ext)
                              || (c_ext == (t_ext + CASE_GAP));
            // At the separator only the name length still has to agree
            assign keep     = i_is_sep ? (i_pos == POS_W'(CMD_LENS[k]))
                                       : (in_range && byte_ok);
            assign o_flags[k] = i_flags[k] & keep;
        end else begin : g_none
            assign o_flags[k] = 1'b0;
        end
    end

endmodule

>>> src/cfm_arg_accum.sv
// ----------------------------------------------------------------------------
// cfm_arg_accum - decimal argument accumulator
// Folds one digit into the running value, flags any non-digit byte.
// ----------------------------------------------------------------------------
module cfm_arg_accum (
    input  cfm_pkg::t_byte i_byte,
    input  cfm_pkg::t_arg  i_acc,
    input  logic           i_bad,
    output cfm_pkg::t_arg  o_acc,
    output logic           o_bad
);
    import cfm_pkg::*;

    logic is_digit;
    t_byte digit;

    assign is_digit = (i_byte >= DIGIT_LO) && (i_byte <= DIGIT_HI);
    assign digit    = i_byte - DIGIT_LO;

    // acc * 10 as two shifts and an add, wrapping at the word width
    assign o_acc = is_digit ? ((i_acc << 3) + (i_acc << 1) + ARG_W'(digit)) : i_acc;
    assign o_bad = i_bad | ~is_digit;

endmodule

>>> tb/sv/command_frame_matcher_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_frame_matcher_test - self-checking testbench for the frame matcher
// Streams name_number frames byte by byte with random idle and stall gaps,
// predicts the per-frame status, command index and argument from its own
// copy of the matching rules, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module command_frame_matcher_test;

    import cfm_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int NAME_SAT     = 16;
    localparam int N_CMDS       = 6;

    // Own copy of the command table, right-justified text
    localparam logic [63:0] CMD_TEXT [N_CMDS] = '{
        "Servo1", "Servo2", "Relayoff", "Relayon", "ledoff", "Ledon"
    };
    localparam int CMD_LEN [N_CMDS] = '{6, 6, 8, 7, 6, 5};

    typedef struct packed {
        t_status status;
        t_index  index;
        t_arg    arg;
    } t_frame_result;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   o_in_stall;
    t_byte  i_char_byte = '0;
    logic   i_is_last   = 1'b0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    logic [1:0] o_frame_status;
    t_index o_command_index;
    t_arg   o_argument_value;

    // Predicted frame state
    logic        num_part;
    logic        digit_error;
    int          name_pos;
    logic [5:0]  cand_flags;
    t_arg        arg_acc;

    t_frame_result expected_results[$];
    t_byte         frame_bytes[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int errors      = 0;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int frames_sent = 0;
    int n_right     = 0;
    int n_wrong_frame  = 0;
    int n_wrong_string = 0;

    command_frame_matcher i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_char_byte      (i_char_byte),
        .i_is_last        (i_is_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_status   (o_frame_status),
        .o_command_index  (o_command_index),
        .o_argument_value (o_argument_value)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("** command_frame_matcher: FAILED **");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    function automatic t_byte name_char(input int k, input int p);
        return CMD_TEXT[k][8*(CMD_LEN[k]-1-p) +: 8];
    endfunction

    // Equal, or one case gap away in either direction
    function automatic logic char_matches(input t_byte c, input t_byte t);
        int a;
        int b;
        a = c;
        b = t;
        return (a == b) || (a + 32 == b) || (a == b + 32);
    endfunction

    task automatic clear_frame_state();
        num_part    = 1'b0;
        digit_error = 1'b0;
        name_pos    = 0;
        cand_flags  = '1;
        arg_acc     = '0;
    endtask

    task automatic predict_frame_byte(input t_byte c, input logic last);
        t_frame_result r;
        int k;
        if (num_part) begin
            if (c >= DIGIT_LO && c <= DIGIT_HI)
                arg_acc = arg_acc * 32'd10 + (32'(c) - 32'(DIGIT_LO));
            else
                digit_error = 1'b1;
        end else if (c == SEP_CHAR) begin
            // name part closes: only exact-length names survive
            for (k = 0; k < N_CMDS; k++)
                if (name_pos != CMD_LEN[k]) cand_flags[k] = 1'b0;
            num_part = 1'b1;
        end else begin
            for (k = 0; k < N_CMDS; k++)
                if (!(name_pos < CMD_LEN[k] && char_matches(c, name_char(k, name_pos))))
                    cand_flags[k] = 1'b0;
            if (name_pos < NAME_SAT) name_pos++;
        end
        if (last) begin
            r = '0;
            if (!num_part || digit_error) begin
                r.status = ST_WRONG_STRING;
                n_wrong_string++;
            end else if (cand_flags == '0) begin
                r.status = ST_WRONG_FRAME;
                n_wrong_frame++;
            end else begin
                r.status = ST_RIGHT_FRAME;
                r.arg    = arg_acc;
                for (k = N_CMDS - 1; k >= 0; k--)
                    if (cand_flags[k]) r.index = t_index'(k);
                n_right++;
            end
            expected_results.push_back(r);
            clear_frame_state();
        end
    endtask

    // Drive one byte transaction; valid stays high into the next call
    task automatic send_char(input t_byte c, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid  <= 1'b0;
            i_char_byte <= t_byte'($urandom);
            i_is_last   <= 1'($urandom);
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_byte <= c;
        i_is_last   <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_frame_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_char(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
        frames_sent++;
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) frame_bytes.push_back(t_byte'(s[i]));
    endtask

    function automatic t_byte case_variant(input t_byte t);
        int v;
        int pick;
        v = t;
        pick = $urandom_range(0, 5);
        if (pick == 1 && v + 32 <= 255) v = v + 32;
        if (pick == 2 && v >= 32) v = v - 32;
        return t_byte'(v);
    endfunction

    task automatic add_name(input int k);
        int p;
        for (p = 0; p < CMD_LEN[k]; p++) frame_bytes.push_back(case_variant(name_char(k, p)));
    endtask

    task automatic add_digits();
        int n;
        int i;
        n = ($urandom_range(0, 99) < 15) ? $urandom_range(10, 12) : $urandom_range(0, 5);
        for (i = 0; i < n; i++) frame_bytes.push_back(DIGIT_LO + t_byte'($urandom_range(0, 9)));
    endtask

    function automatic t_byte non_digit();
        t_byte b;
        do b = t_byte'($urandom); while (b >= DIGIT_LO && b <= DIGIT_HI);
        return b;
    endfunction

    // Every command, case flips, argument extremes and wrap
    task automatic test_command_names();
        add_text("sERVO1_0");             send_frame();
        add_text("Servo2_4294967295");    send_frame();
        add_text("RELAYOFF_99999999999"); send_frame();
        add_text("Relayon_7");            send_frame();
        add_text("ledoff_12");            send_frame();
        add_text("LEDON_");               send_frame();
    endtask

    // Malformed frames
    task automatic test_malformed_frames();
        add_text("Ledon5");        send_frame();   // no separator
        add_text("Ledon_1_2");     send_frame();   // second separator in number
        add_text("Ledon_");
        frame_bytes.push_back(8'h00);              // zero byte in number
        send_frame();
        add_text("Led");
        frame_bytes.push_back(8'h00);              // zero byte in name
        add_text("n_1");           send_frame();
        add_text("Ledonx_1");      send_frame();   // name too long
        add_text("Relay_3");       send_frame();   // name too short
        add_text("AAAAAAAAAAAAAAAAAAAA_1"); send_frame();  // saturating position
        add_text("_");             send_frame();   // empty name
        add_text("x");             send_frame();   // one byte, no separator
        add_text("Relayofx_a");    send_frame();   // bad name and bad digit
        frame_bytes.push_back(8'hFF);
        add_text("edon_9");        send_frame();
    endtask

    // Half well-formed frames with random content, the rest broken ones and noise
    task automatic test_random_traffic(input int n_bytes);
        int stop_at;
        int kind;
        int k;
        int pos;
        int i;
        int n;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            k = $urandom_range(0, N_CMDS - 1);
            if (kind < 50) begin
                add_name(k);
                frame_bytes.push_back(SEP_CHAR);
                add_digits();
            end else if (kind < 62) begin
                add_name(k);
                pos = $urandom_range(0, CMD_LEN[k] - 1);
                frame_bytes[pos] = t_byte'($urandom);
                frame_bytes.push_back(SEP_CHAR);
                add_digits();
            end else if (kind < 70) begin
                add_name(k);
                if ($urandom_range(0, 1)) void'(frame_bytes.pop_back());
                else frame_bytes.push_back(case_variant(8'h61 + t_byte'($urandom_range(0, 25))));
                frame_bytes.push_back(SEP_CHAR);
                add_digits();
            end else if (kind < 78) begin
                add_name(k);
                add_digits();
            end else if (kind < 88) begin
                add_name(k);
                frame_bytes.push_back(SEP_CHAR);
                add_digits();
                pos = $urandom_range(CMD_LEN[k] + 1, frame_bytes.size());
                frame_bytes.insert(pos, non_digit());
            end else begin
                n = $urandom_range(1, 20);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 4))
                        0:       frame_bytes.push_back(SEP_CHAR);
                        1:       frame_bytes.push_back(DIGIT_LO + t_byte'($urandom_range(0, 9)));
                        default: frame_bytes.push_back(t_byte'($urandom));
                    endcase
                end
            end
            send_frame();
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin : check_result
            t_frame_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d index %0d arg %0d",
                         $realtime, o_frame_status, o_command_index, o_argument_value);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_frame_status !== want.status) begin
                    $display("%0t: frame_status mismatch: expected %0d actual %0d",
                             $realtime, want.status, o_frame_status);
                    errors++;
                end
                if (o_command_index !== want.index) begin
                    $display("%0t: command_index mismatch: expected %0d actual %0d",
                             $realtime, want.index, o_command_index);
                    errors++;
                end
                if (o_argument_value !== want.arg) begin
                    $display("%0t: argument_value mismatch: expected %0d actual %0d",
                             $realtime, want.arg, o_argument_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        clear_frame_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 23;
        rx_idle_pct = 50;
        test_command_names();
        test_malformed_frames();
        test_random_traffic(320);

        tx_idle_pct = 50;
        rx_idle_pct = 23;
        test_random_traffic(320);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(320);

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d bytes in %0d frames under three idle/stall mixes.",
                 bytes_sent, frames_sent);
        $display("Results: %0d right frame, %0d wrong frame, %0d wrong string, %0d errors.",
                 n_right, n_wrong_frame, n_wrong_string, errors);
        if (errors == 0) begin
            $display("** command_frame_matcher: PASSED **");
        end else begin
            $display("** command_frame_matcher: FAILED **");
        end
        $finish;
    end

endmodule
